### src/phd_pkg.sv
// Shared types and constants for the peak hold detector.
`timescale 1ns / 1ps
package phd_pkg;

   // Width of the per-buffer sample counter and its saturation value
   localparam int unsigned BUF_CNT_BITS = 16;
   localparam logic [BUF_CNT_BITS-1:0] BUF_CNT_MAX = {BUF_CNT_BITS{1'b1}};

   // Control bits of the word held in the input stage
   typedef struct packed {
      logic valid;
      logic last;
   } phd_ctl_type;

endpackage

### src/phd_abs_stage.sv
// Input register stage: captures a request word and its sample magnitude.
`timescale 1ns / 1ps
module phd_abs_stage #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic                     req_last,
   input  logic                     take,
   output phd_pkg::phd_ctl_type     ctl,
   output logic [SAMPLE_BITS-1:0]   mag
);
   import phd_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   logic                   last_ff;
   logic [SAMPLE_BITS-1:0] mag_ff;
   logic [SAMPLE_BITS-1:0] mag_in;

   // Hold the word while the tracker cannot take it
   assign req_stall = valid_ff & ~take;

   // Two's complement magnitude; the most negative code maps to 2^(N-1)
   assign mag_in = req_sample[SAMPLE_BITS-1] ? (~req_sample + 1'b1) : req_sample;

   assign valid_in = req_valid;

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         last_ff <= req_last;
         mag_ff  <= mag_in;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.last  = last_ff;
   assign mag       = mag_ff;

endmodule

### src/phd_tracker.sv
// Peak tracking state, hold counter and registered result word.
`timescale 1ns / 1ps
module phd_tracker #(
   parameter int unsigned SAMPLE_BITS = 24,
   parameter int unsigned HOLD_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [HOLD_BITS-1:0]     csr_data,
   input  phd_pkg::phd_ctl_type     ctl,
   input  logic [SAMPLE_BITS-1:0]   mag,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SAMPLE_BITS-1:0]   rsp_peak,
   output logic                     rsp_updated
);
   import phd_pkg::*;

   localparam int unsigned FC_W  = HOLD_BITS + 1;
   localparam int unsigned SUM_W = ((FC_W > BUF_CNT_BITS) ? FC_W : BUF_CNT_BITS) + 1;

   logic [HOLD_BITS-1:0]    hold_ff;
   logic [SAMPLE_BITS-1:0]  rmax_ff;
   logic [SAMPLE_BITS-1:0]  rmax_in;
   logic [SAMPLE_BITS-1:0]  peak_ff;
   logic [SAMPLE_BITS-1:0]  peak_in;
   logic [FC_W-1:0]         fc_ff;
   logic [FC_W-1:0]         fc_in;
   logic [BUF_CNT_BITS-1:0] bs_ff;
   logic [BUF_CNT_BITS-1:0] bs_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    upd_ff;

   logic                    out_free;
   logic                    go;
   logic                    go_last;
   logic [SAMPLE_BITS-1:0]  rmax_new;
   logic [BUF_CNT_BITS:0]   bs_plus;
   logic [SUM_W-1:0]        fc_sum;
   logic [FC_W-1:0]         fc_sat;
   logic                    upd;

   // Result slot is free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign take     = ctl.valid & (~ctl.last | out_free);
   assign go       = take;
   assign go_last  = go & ctl.last;

   // Running maximum including the current sample
   assign rmax_new = (mag > rmax_ff) ? mag : rmax_ff;

   // Frames in the closing buffer: floor(count/2), count = bs+1 samples
   assign bs_plus = {1'b0, bs_ff} + 1'b1;
   assign fc_sum  = SUM_W'(fc_ff) + SUM_W'(bs_plus[BUF_CNT_BITS:1]);
   assign fc_sat  = (|fc_sum[SUM_W-1:FC_W]) ? {FC_W{1'b1}} : fc_sum[FC_W-1:0];

   // Refresh when hold time has run out or a louder peak arrived
   assign upd = (fc_sat > FC_W'(hold_ff)) | (peak_ff < rmax_new);

   // Next-state logic
   always_comb begin
      rmax_in = rmax_ff;
      peak_in = peak_ff;
      fc_in   = fc_ff;
      bs_in   = bs_ff;
      if (go) begin
         rmax_in = rmax_new;
         if (!ctl.last) begin
            if (bs_ff < BUF_CNT_MAX) begin
               bs_in = bs_ff + 1'b1;
            end
         end else begin
            bs_in = '0;
            fc_in = fc_sat;
            if (upd) begin
               peak_in = rmax_new;
               rmax_in = rmax_new >> 1;
               fc_in   = '0;
            end
         end
      end
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go_last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold setting register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (csr_write) begin
         hold_ff <= csr_data;
      end
   end

   // Tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         rmax_ff      <= '0;
         peak_ff      <= '0;
         fc_ff        <= '0;
         bs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rmax_ff      <= rmax_in;
         peak_ff      <= peak_in;
         fc_ff        <= fc_in;
         bs_ff        <= bs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result flag
   always_ff @(posedge clock) begin
      if (go_last) begin
         upd_ff <= upd;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_peak    = peak_ff;
   assign rsp_updated = upd_ff;

   // A buffer end always leaves a result word pending
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      go_last |=> rsp_valid_ff)
      else $error("buffer end did not produce a result word");

   // A refresh clears the hold counter
   a_upd_clears_count: assert property (@(posedge clock) disable iff (reset)
      (go_last && upd) |=> (fc_ff == '0))
      else $error("hold counter not cleared on refresh");

   // Running maximum only drops on a refresh
   a_rmax_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(go_last && upd) |=> (rmax_ff >= $past(rmax_ff)))
      else $error("running maximum dropped without refresh");

   // Held peak only changes together with a result word
   a_peak_changes_on_word: assert property (@(posedge clock) disable iff (reset)
      !go_last |=> $stable(peak_ff))
      else $error("held peak changed outside a buffer end");

endmodule

### src/block_peak_hold_detector_core.sv
// Top level of the peak hold level meter.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one signed sample per
//   word, with req_last marking the final sample of a buffer. Response channel
//   (rsp_valid / rsp_stall) carries one word per buffer end: the held peak
//   magnitude and a flag telling whether it was refreshed at that buffer.
//   The hold time in frames is written through csr_write / csr_data while
//   the block is idle.
//   Throughput: one sample per cycle, sustained while no buffer-end sample
//   waits on a stalled result word; the peak, counter and result updates
//   are all registered in the tracker, fed from the input register. A
//   buffer-end sample reaches its result word through two register stages.
//   Reset clears the hold setting, the running maximum, the held peak and
//   both counters, and empties both register stages.
//   When the receiver stalls, the result word holds; samples that close no
//   buffer still flow, and a buffer-end sample waits in the input register,
//   which raises req_stall until the result slot frees up.
`timescale 1ns / 1ps
module block_peak_hold_detector_core #(
   parameter int unsigned SAMPLE_BITS = 24,
   parameter int unsigned HOLD_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [HOLD_BITS-1:0]   csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_peak,
   output logic                   rsp_updated
);
   import phd_pkg::*;

   phd_ctl_type            ctl;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   take;

   // Input register with magnitude
   phd_abs_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_abs_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .take       (take),
      .ctl        (ctl),
      .mag        (mag)
   );

   // Peak state and result register
   phd_tracker #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .HOLD_BITS   (HOLD_BITS)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .ctl         (ctl),
      .mag         (mag),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_peak    (rsp_peak),
      .rsp_updated (rsp_updated)
   );

endmodule
